>>> rtl/core/imd_pkg.sv
// Shared types, codes and type tables for the ITCH message deframer.
package imd_pkg;

  typedef enum logic [1:0] {
    PH_LEN_HI = 2'd0,
    PH_LEN_LO = 2'd1,
    PH_BODY   = 2'd2,
    PH_SKIP   = 2'd3
  } imd_phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LEN   = 2'd1,
    ST_TRUNCATED = 2'd2,
    ST_ZERO_LEN  = 2'd3
  } imd_status_t;

  localparam int unsigned LenW = 6;

  typedef struct packed {
    logic [7:0]  msg_type;
    logic        known_type;
    imd_status_t status;
    logic [15:0] locate_id;
    logic [15:0] track_seq;
    logic [47:0] timestamp;
    logic [63:0] order_reference;
    logic        end_of_buffer;
  } imd_result_t;

  // Required message length per type, zero for types outside the list.
  function automatic logic [LenW-1:0] imd_known_len(input logic [7:0] t);
    logic [LenW-1:0] len;
    case (t)
      8'h53:   len = LenW'(12); // S
      8'h52:   len = LenW'(39); // R
      8'h48:   len = LenW'(25); // H
      8'h59:   len = LenW'(20); // Y
      8'h4C:   len = LenW'(26); // L
      8'h56:   len = LenW'(35); // V
      8'h57:   len = LenW'(12); // W
      8'h4B:   len = LenW'(28); // K
      8'h41:   len = LenW'(36); // A
      8'h46:   len = LenW'(40); // F
      8'h45:   len = LenW'(31); // E
      8'h43:   len = LenW'(36); // C
      8'h58:   len = LenW'(23); // X
      8'h44:   len = LenW'(19); // D
      8'h55:   len = LenW'(35); // U
      8'h50:   len = LenW'(44); // P
      8'h51:   len = LenW'(40); // Q
      8'h42:   len = LenW'(19); // B
      8'h49:   len = LenW'(50); // I
      8'h4E:   len = LenW'(20); // N
      8'h4A:   len = LenW'(35); // J
      default: len = '0;
    endcase
    return len;
  endfunction

  // Types whose body carries an order reference number.
  function automatic logic imd_has_ref(input logic [7:0] t);
    logic r;
    case (t)
      8'h41, 8'h46, 8'h45, 8'h43, 8'h58, 8'h44, 8'h55, 8'h50: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/itch_message_deframer_core.sv
// Top level of the ITCH frame deframer and header extractor.
//
//   channel  dir  handshake              beat
//   in_      in   in_valid / in_ready    one raw byte, buffer_end flag
//   out_     out  out_valid / out_ready  one frame result
//
// One byte per cycle; a result is registered and leaves in the cycle after the byte that ends its frame.
// The result register sets the rate: in_ready drops only while a result waits
// and out_ready is low.
// Synchronous active-low reset returns the block to expecting a length high byte.
// Bytes after an error are consumed silently up to the end of the buffer.
module itch_message_deframer_core
  import imd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_buffer_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_msg_type,
  output logic        out_known_type,
  output logic [1:0]  out_status,
  output logic [15:0] out_locate_id,
  output logic [15:0] out_track_seq,
  output logic [47:0] out_timestamp,
  output logic [63:0] out_order_reference,
  output logic        out_end_of_buffer
);

  logic        beat_en;
  logic        res_valid;
  logic        free;
  imd_result_t res;
  imd_result_t res_q;

  assign in_ready = free;
  assign beat_en  = in_valid && free;

  imd_frame_fsm u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_en    (beat_en),
    .data_byte  (in_data_byte),
    .buffer_end (in_buffer_end),
    .res_valid  (res_valid),
    .res        (res)
  );

  imd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (beat_en && res_valid),
    .res_in    (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (free),
    .res_out   (res_q)
  );

  assign out_msg_type        = res_q.msg_type;
  assign out_known_type      = res_q.known_type;
  assign out_status          = res_q.status;
  assign out_locate_id       = res_q.locate_id;
  assign out_track_seq       = res_q.track_seq;
  assign out_timestamp       = res_q.timestamp;
  assign out_order_reference = res_q.order_reference;
  assign out_end_of_buffer   = res_q.end_of_buffer;

endmodule

>>> rtl/core/imd_frame_fsm.sv
// Frame phase tracking, header field capture and result formation.
module imd_frame_fsm
  import imd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        beat_en,
  input  logic [7:0]  data_byte,
  input  logic        buffer_end,
  output logic        res_valid,
  output imd_result_t res
);

  imd_phase_t  phase_r, phase_nxt;
  logic [15:0] frame_len_r, frame_len_nxt;
  logic [15:0] seen_r, seen_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] locate_r, locate_nxt;
  logic [15:0] track_r, track_nxt;
  logic [47:0] time_r, time_nxt;
  logic [63:0] ref_r, ref_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN_HI;
    end else if (beat_en) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_en) begin
      frame_len_r <= frame_len_nxt;
      seen_r      <= seen_nxt;
      type_r      <= type_nxt;
      locate_r    <= locate_nxt;
      track_r     <= track_nxt;
      time_r      <= time_nxt;
      ref_r       <= ref_nxt;
    end
  end

  logic [LenW-1:0] need;
  logic            have_type;
  imd_status_t     st;

  always_comb begin
    phase_nxt     = phase_r;
    frame_len_nxt = frame_len_r;
    seen_nxt      = seen_r;
    type_nxt      = type_r;
    locate_nxt    = locate_r;
    track_nxt     = track_r;
    time_nxt      = time_r;
    ref_nxt       = ref_r;
    res_valid     = 1'b0;
    have_type     = 1'b0;
    st            = ST_OK;
    need          = '0;

    case (phase_r)
      PH_LEN_HI: begin
        seen_nxt      = '0;
        type_nxt      = '0;
        locate_nxt    = '0;
        track_nxt     = '0;
        time_nxt      = '0;
        ref_nxt       = '0;
        frame_len_nxt = {data_byte, 8'h00};
        if (buffer_end) begin
          res_valid = 1'b1;
          st        = ST_TRUNCATED;
          phase_nxt = PH_LEN_HI;
        end else begin
          phase_nxt = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        frame_len_nxt = {frame_len_r[15:8], data_byte};
        if (frame_len_nxt == 16'd0) begin
          res_valid = 1'b1;
          st        = ST_ZERO_LEN;
          phase_nxt = buffer_end ? PH_LEN_HI : PH_SKIP;
        end else if (buffer_end) begin
          res_valid = 1'b1;
          st        = ST_TRUNCATED;
          phase_nxt = PH_LEN_HI;
        end else begin
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        have_type = 1'b1;
        if (seen_r == 16'd0) begin
          type_nxt = data_byte;
        end
        if (seen_r == 16'd1) locate_nxt[15:8] = data_byte;
        if (seen_r == 16'd2) locate_nxt[7:0]  = data_byte;
        if (seen_r == 16'd3) track_nxt[15:8]  = data_byte;
        if (seen_r == 16'd4) track_nxt[7:0]   = data_byte;
        for (int i = 0; i < 6; i++) begin
          if (seen_r == 16'(10 - i)) time_nxt[8*i +: 8] = data_byte;
        end
        for (int i = 0; i < 8; i++) begin
          if (seen_r == 16'(18 - i)) ref_nxt[8*i +: 8] = data_byte;
        end
        seen_nxt = seen_r + 16'd1;
        need     = imd_known_len(type_nxt);
        if (seen_nxt == frame_len_r) begin
          res_valid = 1'b1;
          st = (need != '0 && {{(16-LenW){1'b0}}, need} != frame_len_r) ? ST_BAD_LEN : ST_OK;
          phase_nxt = (st != ST_OK && !buffer_end) ? PH_SKIP : PH_LEN_HI;
        end else if (buffer_end) begin
          res_valid = 1'b1;
          st        = ST_TRUNCATED;
          phase_nxt = PH_LEN_HI;
        end
      end
      PH_SKIP: begin
        if (buffer_end) phase_nxt = PH_LEN_HI;
      end
      default: begin
        phase_nxt = PH_LEN_HI;
      end
    endcase
  end

  always_comb begin
    res.msg_type        = have_type ? type_nxt : 8'h00;
    res.known_type      = have_type && (imd_known_len(type_nxt) != '0);
    res.status          = st;
    res.locate_id       = locate_nxt;
    res.track_seq       = track_nxt;
    res.timestamp       = time_nxt;
    res.order_reference = (have_type && imd_has_ref(type_nxt)) ? ref_nxt : 64'd0;
    res.end_of_buffer   = buffer_end;
  end

endmodule

>>> rtl/core/imd_out_reg.sv
// Result register with valid/ready handshake toward the consumer.
module imd_out_reg
  import imd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  imd_result_t res_in,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        free,
  output imd_result_t res_out
);

  logic        valid_r, valid_nxt;
  imd_result_t res_r;

  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule
